// ----- rtl/dtmf_tone_generator_macros.svh -----
// Assertion macros shared by the DTMF tone generator checker.
// No dependencies; included by the files that assert.
`ifndef DTMF_TONE_GENERATOR_MACROS_SVH
`define DTMF_TONE_GENERATOR_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define DTG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked through reset as well.
`define DTG_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/dtg_pkg.sv -----
// Shared types, constants and elaboration-time tables of the DTMF tone generator.
// No dependencies; used by dtmf_tone_generator and dtg_checker.
package dtg_pkg;

   localparam int SAMPLE_RATE  = 8000;
   localparam int SINE_ENTRIES = 256;
   localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
   localparam int AMP_BITS     = 14;
   localparam int PHASE_BITS   = 32;
   localparam int COUNT_BITS   = 16;
   localparam int SAMPLE_BITS  = 16;
   localparam int STATUS_BITS  = 3;
   localparam int KEY_BITS     = 8;
   localparam int CFG_BITS     = 16;
   localparam int NUM_KEYS     = 16;

   localparam logic [AMP_BITS-1:0] AMPLITUDE = 14'd16383;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic ACTION_KEY  = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_SAMPLE = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_IDLE   = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_KEY_OK = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD    = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_BUSY   = 3'd4;

   localparam logic CSR_TONE_SAMPLES  = 1'b0;
   localparam logic CSR_PAUSE_SAMPLES = 1'b1;

   localparam logic [CFG_BITS-1:0] TONE_SAMPLES_RESET  = 16'd320;
   localparam logic [CFG_BITS-1:0] PAUSE_SAMPLES_RESET = 16'd320;

   typedef logic [AMP_BITS-1:0] sine_type;
   typedef sine_type sine_table_type [SINE_ENTRIES];
   typedef logic [KEY_BITS-1:0] key_table_type [NUM_KEYS];
   typedef logic [PHASE_BITS-1:0] step_table_type [4];

   // row-major keypad: index = row * 4 + column
   localparam key_table_type KEY_LAYOUT = '{
      8'h31, 8'h32, 8'h33, 8'h41,
      8'h34, 8'h35, 8'h36, 8'h42,
      8'h37, 8'h38, 8'h39, 8'h43,
      8'h2A, 8'h30, 8'h23, 8'h44
   };

   localparam logic [63:0] HALF_RATE = 64'(SAMPLE_RATE / 2);
   localparam logic [63:0] RATE_64   = 64'(SAMPLE_RATE);

   localparam step_table_type ROW_STEPS = '{
      PHASE_BITS'(((64'd697 << 32) + HALF_RATE) / RATE_64),
      PHASE_BITS'(((64'd770 << 32) + HALF_RATE) / RATE_64),
      PHASE_BITS'(((64'd852 << 32) + HALF_RATE) / RATE_64),
      PHASE_BITS'(((64'd941 << 32) + HALF_RATE) / RATE_64)
   };

   localparam step_table_type COL_STEPS = '{
      PHASE_BITS'(((64'd1209 << 32) + HALF_RATE) / RATE_64),
      PHASE_BITS'(((64'd1336 << 32) + HALF_RATE) / RATE_64),
      PHASE_BITS'(((64'd1477 << 32) + HALF_RATE) / RATE_64),
      PHASE_BITS'(((64'd1633 << 32) + HALF_RATE) / RATE_64)
   };

   // Q30 Taylor series of sin, evaluated at elaboration only
   function automatic sine_type quarter_sine(input int unsigned idx);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] v;
      logic signed [63:0] acc;
      x    = (64'(idx) * HALF_PI_Q30 + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES);
      x2   = (x * x) >> 30;
      acc  = $signed(x);
      term = ((x * x2) >> 30) / 64'd6;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      acc  = acc + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      acc  = acc + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      acc  = acc + $signed(term);
      term = ((term * x2) >> 30) / 64'd210;
      acc  = acc - $signed(term);
      if (acc < 0) begin
         acc = 64'sd0;
      end
      v = ($unsigned(acc) * 64'(AMPLITUDE) + (64'd1 << 29)) >> 30;
      if (v > 64'(AMPLITUDE)) begin
         v = 64'(AMPLITUDE);
      end
      return AMP_BITS'(v);
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type t;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         t[i] = quarter_sine(i);
      end
      return t;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

   // one quarter-wave lookup with quadrant folding
   function automatic logic signed [AMP_BITS:0] wave(input logic [PHASE_BITS-1:0] phase);
      logic [1:0]           quad;
      logic [SINE_BITS-1:0] j;
      logic [SINE_BITS-1:0] mirror;
      sine_type             mag;
      quad   = phase[PHASE_BITS-1 -: 2];
      j      = phase[PHASE_BITS-3 -: SINE_BITS];
      mirror = ~j + 1'b1;
      if (quad[0]) begin
         mag = (j == '0) ? AMPLITUDE : SINE_TABLE[mirror];
      end else begin
         mag = SINE_TABLE[j];
      end
      return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

// ----- rtl/dtmf_tone_generator.sv -----
// DTMF tone generator: top level with key decode, phase accumulators and sine lookup.
// Depends on dtg_pkg for tables, steps and status codes.
//
// Each request transaction either loads a keypad character (action 0) or asks for one
// sample (action 1), and every request yields exactly one response transaction. A
// valid key starts a digit: pause_samples zero samples, then tone_samples samples of
// the row sine plus the column sine, each of amplitude 16383, phases starting at zero.
// A new request is taken every clock cycle unless rsp_stall holds the output. Each request
// passes the input register, then the result register, with the phase add, both quarter-wave
// table lookups and the sum done in the single combinational pass between them. Write
// tone_samples (index 0) and pause_samples (index 1) through the csr_ port while no
// transaction is in flight; a write applies from the next request on, even mid-digit.
module dtmf_tone_generator (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_action,
   input  logic [dtg_pkg::KEY_BITS-1:0]            req_key_char,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [dtg_pkg::SAMPLE_BITS-1:0]  rsp_sample,
   output logic [dtg_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic                                    rsp_last_sample,
   input  logic                                    csr_write,
   input  logic                                    csr_index,
   input  logic [dtg_pkg::CFG_BITS-1:0]            csr_wdata
);

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_PAUSE = 2'd1;
   localparam logic [1:0] MODE_TONE  = 2'd2;

   logic [dtg_pkg::CFG_BITS-1:0]            tone_samples_ff, tone_samples_in;
   logic [dtg_pkg::CFG_BITS-1:0]            pause_samples_ff, pause_samples_in;

   logic                                    in_valid_ff, in_valid_in;
   logic                                    in_action_ff;
   logic [dtg_pkg::KEY_BITS-1:0]            in_key_ff;

   logic [1:0]                              mode_ff, mode_in;
   logic [1:0]                              row_ff, row_in;
   logic [1:0]                              col_ff, col_in;
   logic [dtg_pkg::COUNT_BITS-1:0]          count_ff, count_in;
   logic [dtg_pkg::PHASE_BITS-1:0]          low_phase_ff, low_phase_in;
   logic [dtg_pkg::PHASE_BITS-1:0]          high_phase_ff, high_phase_in;

   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [dtg_pkg::SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [dtg_pkg::STATUS_BITS-1:0]         status_ff, status_in;
   logic                                    last_ff, last_in;

   logic                                    out_free;
   logic                                    advance;
   logic                                    accept;
   logic                                    key_hit;
   logic [3:0]                              key_idx;
   logic [dtg_pkg::COUNT_BITS-1:0]          count_inc;
   logic signed [dtg_pkg::AMP_BITS:0]       low_wave;
   logic signed [dtg_pkg::AMP_BITS:0]       high_wave;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_comb begin
      tone_samples_in  = tone_samples_ff;
      pause_samples_in = pause_samples_ff;
      if (csr_write) begin
         case (csr_index)
            dtg_pkg::CSR_TONE_SAMPLES:  tone_samples_in  = csr_wdata;
            dtg_pkg::CSR_PAUSE_SAMPLES: pause_samples_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      key_hit = 1'b0;
      key_idx = '0;
      for (int k = 0; k < dtg_pkg::NUM_KEYS; k++) begin
         if (!key_hit && in_key_ff == dtg_pkg::KEY_LAYOUT[k]) begin
            key_hit = 1'b1;
            key_idx = 4'(k);
         end
      end
   end

   assign count_inc = count_ff + 1'b1;
   assign low_wave  = dtg_pkg::wave(low_phase_ff);
   assign high_wave = dtg_pkg::wave(high_phase_ff);

   always_comb begin
      mode_in       = mode_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      count_in      = count_ff;
      low_phase_in  = low_phase_ff;
      high_phase_in = high_phase_ff;
      sample_in     = '0;
      status_in     = dtg_pkg::STATUS_IDLE;
      last_in       = 1'b0;
      if (in_action_ff == dtg_pkg::ACTION_KEY) begin
         if (mode_ff != MODE_IDLE) begin
            status_in = dtg_pkg::STATUS_BUSY;
         end else if (key_hit) begin
            status_in     = dtg_pkg::STATUS_KEY_OK;
            row_in        = key_idx[3:2];
            col_in        = key_idx[1:0];
            count_in      = '0;
            low_phase_in  = '0;
            high_phase_in = '0;
            mode_in       = (pause_samples_ff == '0) ? MODE_TONE : MODE_PAUSE;
         end else begin
            status_in = dtg_pkg::STATUS_BAD;
         end
      end else begin
         case (mode_ff)
            MODE_PAUSE: begin
               status_in = dtg_pkg::STATUS_SAMPLE;
               count_in  = count_inc;
               if (count_inc >= pause_samples_ff || count_inc == '0) begin
                  mode_in  = MODE_TONE;
                  count_in = '0;
               end
            end
            MODE_TONE: begin
               status_in     = dtg_pkg::STATUS_SAMPLE;
               sample_in     = dtg_pkg::SAMPLE_BITS'(low_wave) +
                               dtg_pkg::SAMPLE_BITS'(high_wave);
               low_phase_in  = low_phase_ff + dtg_pkg::ROW_STEPS[row_ff];
               high_phase_in = high_phase_ff + dtg_pkg::COL_STEPS[col_ff];
               count_in      = count_inc;
               if (count_inc >= tone_samples_ff || count_inc == '0) begin
                  last_in  = 1'b1;
                  mode_in  = MODE_IDLE;
                  count_in = '0;
               end
            end
            default: begin
               mode_in   = MODE_IDLE;
               status_in = dtg_pkg::STATUS_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_samples_ff  <= dtg_pkg::TONE_SAMPLES_RESET;
         pause_samples_ff <= dtg_pkg::PAUSE_SAMPLES_RESET;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         mode_ff          <= MODE_IDLE;
         count_ff         <= '0;
      end else begin
         tone_samples_ff  <= tone_samples_in;
         pause_samples_ff <= pause_samples_in;
         in_valid_ff      <= in_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (advance) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_action_ff <= req_action;
         in_key_ff    <= req_key_char;
      end
      if (advance) begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         low_phase_ff  <= low_phase_in;
         high_phase_ff <= high_phase_in;
         sample_ff     <= sample_in;
         status_ff     <= status_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = sample_ff;
   assign rsp_status      = status_ff;
   assign rsp_last_sample = last_ff;

endmodule

// ----- rtl/dtg_checker.sv -----
// Port-level checker for the DTMF tone generator, bound to the top level.
// Depends on dtg_pkg and dtmf_tone_generator_macros.svh.
`include "dtmf_tone_generator_macros.svh"

module dtg_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [dtg_pkg::SAMPLE_BITS-1:0]  rsp_sample,
   input logic [dtg_pkg::STATUS_BITS-1:0]         rsp_status,
   input logic                                    rsp_last_sample
);

   `DTG_ASSERT_IMPLY(a_last_is_sample, clock, reset, rsp_valid && rsp_last_sample, rsp_status == dtg_pkg::STATUS_SAMPLE, "last_sample on a non-sample response")
   `DTG_ASSERT_IMPLY(a_quiet_non_sample, clock, reset, rsp_valid && rsp_status != dtg_pkg::STATUS_SAMPLE, rsp_sample == '0 && !rsp_last_sample, "non-sample response carries data")
   `DTG_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_valid, "response valid right after reset")
   `DTG_ASSERT_NEXT(a_stall_hold, clock, !reset && rsp_valid && rsp_stall, reset || (rsp_valid && $stable(rsp_sample) && $stable(rsp_status) && $stable(rsp_last_sample)), "stalled response changed")

endmodule

bind dtmf_tone_generator dtg_checker u_dtg_checker (.*);
